FILE: rtl/gtph_pkg.sv
// Shared codes, constants and the arctangent table for the heading PID core.
package gtph_pkg;

    // input item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_DRIVE    = 2'd0;
    localparam logic [1:0] STAT_ARRIVED  = 2'd1;
    localparam logic [1:0] STAT_CANCELED = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_GOAL_X    = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y    = 3'd1;
    localparam logic [2:0] CFG_RADIUS    = 3'd2;
    localparam logic [2:0] CFG_KP        = 3'd3;
    localparam logic [2:0] CFG_KI        = 3'd4;
    localparam logic [2:0] CFG_KD        = 3'd5;
    localparam logic [2:0] CFG_SPEED     = 3'd6;
    localparam logic [2:0] CFG_MAX_TURN  = 3'd7;

    localparam int CFG_W    = 24;   // widest register
    localparam int ZW       = 21;   // CORDIC angle, rad*2^16
    localparam int NW       = 54;   // PID numerator
    localparam int MAG_W    = 48;   // padded integrator magnitude
    localparam int PI16     = 205887;
    localparam int HALF_PI16 = 102944;
    localparam int PI13     = 25736;
    localparam int TWO_PI13 = 51472;

    localparam logic [50:0] ITERM_LIMIT = 51'h4_0000_0000_0000;

    // atan(2^-i) in rad*2^16, step 0 is 45 degrees scaled by the CORDIC convention
    function automatic logic [16:0] atan_step(input logic [4:0] i);
        logic [16:0] v;
        begin
            case (i)
                5'd0:    v = 17'd51472;
                5'd1:    v = 17'd30386;
                5'd2:    v = 17'd16055;
                5'd3:    v = 17'd8150;
                5'd4:    v = 17'd4091;
                5'd5:    v = 17'd2047;
                5'd6:    v = 17'd1024;
                5'd7:    v = 17'd512;
                5'd8:    v = 17'd256;
                5'd9:    v = 17'd128;
                5'd10:   v = 17'd64;
                5'd11:   v = 17'd32;
                5'd12:   v = 17'd16;
                5'd13:   v = 17'd8;
                5'd14:   v = 17'd4;
                5'd15:   v = 17'd2;
                5'd16:   v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/go_to_point_heading_pid_core.sv
// Go-to-goal controller: distance, bearing and heading PID on one shared sequencer.
//
// Input channel (in_valid / in_stall) takes start, cancel and position tick
// requests. A start arms the block for the goal in goal_x/goal_y; a cancel
// while armed returns one canceled result. Ticks and cancels while idle and
// unknown kinds are dropped without a result.
// An armed tick runs: 3 multiplier passes (dx^2, dy^2, R^2), 32 square-root
// steps with the CORDIC steps in the same cycles, an angle/integrator step,
// 5 multiplier passes (kp, kd, two ki halves, speed gain) and a PID step.
// A cancel result is valid the cycle after it is taken; a start gives no
// result. All passes share one 33x33 multiplier. On arrival a stop result
// follows the drive result.
// in_stall stays high from acceptance until the last result of the request is
// taken, so one request is in work at a time. When out_stall is high the
// result register simply holds. Reset (rst_n low, async) disarms the block,
// clears integrator and previous error and loads the register defaults.
// Configuration writes land immediately; issue them only while idle.
module go_to_point_heading_pid_core #(
    parameter int MAX_FORWARD_SPEED = 6554,
    parameter int COORD_WIDTH       = 16,
    parameter int CORDIC_STEPS      = 16,
    parameter int INTEGRAL_WIDTH    = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [gtph_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic signed [COORD_WIDTH-1:0] robot_x,
    input  logic signed [COORD_WIDTH-1:0] robot_y,
    input  logic signed [15:0]            robot_heading,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   linear_vel,
    output logic signed [20:0]            angular_vel,
    output logic signed [15:0]            target_bearing,
    output logic signed [16:0]            heading_error,
    output logic [1:0]                    status,
    output logic                          last
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int SW  = 2 * COORD_WIDTH + 1;
    localparam int XW  = COORD_WIDTH + 23;
    localparam int IW  = INTEGRAL_WIDTH;
    localparam int ZW  = gtph_pkg::ZW;
    localparam int NW  = gtph_pkg::NW;
    localparam int MAG_PAD_W = gtph_pkg::MAG_W;

    localparam logic signed [IW:0] IMAX = {2'b00, {(IW-1){1'b1}}};
    localparam logic signed [IW:0] IMIN = {2'b11, {(IW-1){1'b0}}};

    // step numbers of the two multiplier phases
    localparam logic [4:0] M1_DXX = 5'd0;
    localparam logic [4:0] M1_DYY = 5'd1;
    localparam logic [4:0] M1_RR  = 5'd2;
    localparam logic [4:0] M1_END = 5'd3;
    localparam logic [4:0] M2_KP  = 5'd0;
    localparam logic [4:0] M2_KD  = 5'd1;
    localparam logic [4:0] M2_KLO = 5'd2;
    localparam logic [4:0] M2_KHI = 5'd3;
    localparam logic [4:0] M2_SG  = 5'd4;
    localparam logic [4:0] M2_END = 5'd5;
    localparam logic [4:0] IT_END = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ITER,
        ST_ANGLE,
        ST_MUL2,
        ST_PID,
        ST_OUT
    } state_t;

    // configuration
    logic signed [COORD_WIDTH-1:0] goal_x_reg, goal_y_reg;
    logic [15:0] radius_reg;
    logic [23:0] kp_reg, ki_reg, kd_reg, sg_reg;
    logic [19:0] mtr_reg;

    // control and state
    state_t state_reg;
    logic [4:0] cnt_reg;
    logic running_reg;
    logic stop_pend_reg;
    logic signed [IW-1:0] integ_reg;
    logic signed [16:0] prev_reg;
    logic out_valid_reg;
    logic [15:0] lin_out_reg;
    logic signed [20:0] ang_out_reg;
    logic signed [15:0] bear_out_reg;
    logic signed [16:0] err_out_reg;
    logic [1:0] status_reg;
    logic last_reg;

    // datapath
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [15:0] head_reg;
    logic signed [65:0] prod_reg;
    logic [SW-1:0] s_reg;
    logic [31:0] r2_reg;
    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic signed [XW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic nz_reg;
    logic signed [15:0] bear_reg;
    logic signed [16:0] err_reg;
    logic signed [17:0] de_reg;
    logic arrived_reg;
    logic [IW-1:0] mag_reg;
    logic signed [NW-1:0] acc_reg;
    logic [47:0] ilo_reg;
    logic signed [51:0] iterm_reg;
    logic [15:0] lin_reg;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic [MAG_PAD_W-1:0] mag_pad;

    always_comb
    begin
        mag_pad = MAG_PAD_W'(mag_reg);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL1:
            begin
                case (cnt_reg)
                    M1_DXX:
                    begin
                        mul_a = 33'(dx_reg);
                        mul_b = 33'(dx_reg);
                    end
                    M1_DYY:
                    begin
                        mul_a = 33'(dy_reg);
                        mul_b = 33'(dy_reg);
                    end
                    M1_RR:
                    begin
                        mul_a = 33'(radius_reg);
                        mul_b = 33'(radius_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_MUL2:
            begin
                case (cnt_reg)
                    M2_KP:
                    begin
                        mul_a = 33'(kp_reg);
                        mul_b = 33'(err_reg);
                    end
                    M2_KD:
                    begin
                        mul_a = 33'(kd_reg);
                        mul_b = 33'(de_reg);
                    end
                    M2_KLO:
                    begin
                        mul_a = 33'(ki_reg);
                        mul_b = 33'(mag_pad[23:0]);
                    end
                    M2_KHI:
                    begin
                        mul_a = 33'(ki_reg);
                        mul_b = 33'(mag_pad[47:24]);
                    end
                    M2_SG:
                    begin
                        mul_a = 33'(sg_reg);
                        mul_b = 33'(sq_res_reg[31:0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one square-root step
    logic [63:0] sq_try, sq_v_next, sq_res_next;
    always_comb
    begin
        sq_try = sq_res_reg + sq_bit_reg;
        if (sq_v_reg >= sq_try)
        begin
            sq_v_next   = sq_v_reg - sq_try;
            sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
        end
        else
        begin
            sq_v_next   = sq_v_reg;
            sq_res_next = sq_res_reg >> 1;
        end
    end

    // one CORDIC vectoring step
    logic signed [XW-1:0] cxs, cys, cx_next, cy_next;
    logic signed [ZW-1:0] cz_next, atan_v;
    always_comb
    begin
        cxs = cx_reg >>> cnt_reg;
        cys = cy_reg >>> cnt_reg;
        atan_v = $signed(ZW'(gtph_pkg::atan_step(cnt_reg)));
        if (cy_reg > 0)
        begin
            cx_next = cx_reg + cys;
            cy_next = cy_reg - cxs;
            cz_next = cz_reg + atan_v;
        end
        else
        begin
            cx_next = cx_reg - cys;
            cy_next = cy_reg + cxs;
            cz_next = cz_reg - atan_v;
        end
    end

    // CORDIC start vector
    logic signed [XW-1:0] cx0, cy0;
    logic signed [ZW-1:0] cz0;
    always_comb
    begin
        cx0 = XW'(dx_reg) <<< 20;
        cy0 = XW'(dy_reg) <<< 20;
        cz0 = '0;
        if (dx_reg < 0)
        begin
            cz0 = (dy_reg >= 0) ? ZW'(gtph_pkg::PI16) : -ZW'(gtph_pkg::PI16);
            cx0 = -cx0;
            cy0 = -cy0;
        end
    end

    // bearing wrap, heading error and integrator update
    logic signed [ZW-1:0] zf, bw;
    logic signed [15:0] bear_c;
    logic signed [16:0] err_c;
    logic signed [IW:0] isum;
    logic signed [IW-1:0] integ_c;
    logic near_c, arrived_c;
    always_comb
    begin
        zf = cz_reg + ZW'(gtph_pkg::HALF_PI16);
        bw = (zf + ZW'(4)) >>> 3;
        if (bw > ZW'(gtph_pkg::PI13))
        begin
            bw = bw - ZW'(gtph_pkg::TWO_PI13);
        end
        bear_c = bw[15:0];
        err_c = 17'(bear_c) - 17'(head_reg);
        near_c = 64'(s_reg) < (64'(r2_reg) << 2);
        arrived_c = 64'(s_reg) <= 64'(r2_reg);
        isum = (near_c ? '0 : (IW+1)'(integ_reg)) + (IW+1)'(err_c);
        if (isum[IW] != isum[IW-1])
        begin
            integ_c = isum[IW] ? IMIN[IW-1:0] : IMAX[IW-1:0];
        end
        else
        begin
            integ_c = isum[IW-1:0];
        end
    end

    // integral term: join halves, saturate, apply sign
    logic [72:0] itot;
    logic [50:0] ival;
    logic signed [51:0] iterm_c;
    always_comb
    begin
        itot = 73'(ilo_reg) + (73'(prod_reg[47:0]) << 24);
        ival = (itot > 73'(gtph_pkg::ITERM_LIMIT)) ? gtph_pkg::ITERM_LIMIT : itot[50:0];
        iterm_c = integ_reg[IW-1] ? -$signed({1'b0, ival}) : $signed({1'b0, ival});
    end

    // forward speed
    logic [40:0] lin_full;
    logic [15:0] lin_c;
    always_comb
    begin
        lin_full = prod_reg[55:15];
        lin_c = (lin_full > 41'(MAX_FORWARD_SPEED)) ? 16'(MAX_FORWARD_SPEED) : lin_full[15:0];
    end

    // PID sum, clamp and sign flip
    logic signed [NW-1:0] num_c, pid_c, mtr_s;
    logic signed [20:0] ang_c;
    always_comb
    begin
        num_c = acc_reg + NW'(iterm_reg);
        pid_c = num_c >>> 13;
        mtr_s = $signed(NW'(mtr_reg));
        if (pid_c > mtr_s)
        begin
            pid_c = mtr_s;
        end
        else if (pid_c < -mtr_s)
        begin
            pid_c = -mtr_s;
        end
        ang_c = -pid_c[20:0];
    end

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            radius_reg <= 16'd50;
            kp_reg     <= 24'd6554;
            ki_reg     <= 24'd66;
            kd_reg     <= 24'd65536;
            sg_reg     <= 24'd6711;
            mtr_reg    <= 20'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gtph_pkg::CFG_GOAL_X:   goal_x_reg <= cfg_wdata[COORD_WIDTH-1:0];
                gtph_pkg::CFG_GOAL_Y:   goal_y_reg <= cfg_wdata[COORD_WIDTH-1:0];
                gtph_pkg::CFG_RADIUS:   radius_reg <= cfg_wdata[15:0];
                gtph_pkg::CFG_KP:       kp_reg     <= cfg_wdata[23:0];
                gtph_pkg::CFG_KI:       ki_reg     <= cfg_wdata[23:0];
                gtph_pkg::CFG_KD:       kd_reg     <= cfg_wdata[23:0];
                gtph_pkg::CFG_SPEED:    sg_reg     <= cfg_wdata[23:0];
                gtph_pkg::CFG_MAX_TURN: mtr_reg    <= cfg_wdata[19:0];
                default:                mtr_reg    <= mtr_reg;
            endcase
        end
    end

    // sequencer, controller state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            running_reg   <= 1'b0;
            stop_pend_reg <= 1'b0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            lin_out_reg   <= '0;
            ang_out_reg   <= '0;
            bear_out_reg  <= '0;
            err_out_reg   <= '0;
            status_reg    <= gtph_pkg::STAT_DRIVE;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (kind)
                            gtph_pkg::KIND_START:
                            begin
                                running_reg <= 1'b1;
                            end
                            gtph_pkg::KIND_CANCEL:
                            begin
                                if (running_reg)
                                begin
                                    running_reg   <= 1'b0;
                                    out_valid_reg <= 1'b1;
                                    lin_out_reg   <= '0;
                                    ang_out_reg   <= '0;
                                    bear_out_reg  <= '0;
                                    err_out_reg   <= '0;
                                    status_reg    <= gtph_pkg::STAT_CANCELED;
                                    last_reg      <= 1'b1;
                                    stop_pend_reg <= 1'b0;
                                    state_reg     <= ST_OUT;
                                end
                            end
                            gtph_pkg::KIND_TICK:
                            begin
                                if (running_reg)
                                begin
                                    cnt_reg   <= '0;
                                    state_reg <= ST_MUL1;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MUL1:
                begin
                    if (cnt_reg == M1_END)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ITER;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_ITER:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == IT_END)
                    begin
                        state_reg <= ST_ANGLE;
                    end
                end
                ST_ANGLE:
                begin
                    integ_reg <= integ_c;
                    prev_reg  <= err_c;
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == M2_END)
                    begin
                        state_reg <= ST_PID;
                    end
                end
                ST_PID:
                begin
                    out_valid_reg <= 1'b1;
                    lin_out_reg   <= lin_reg;
                    ang_out_reg   <= ang_c;
                    bear_out_reg  <= bear_reg;
                    err_out_reg   <= err_reg;
                    status_reg    <= gtph_pkg::STAT_DRIVE;
                    last_reg      <= !arrived_reg;
                    stop_pend_reg <= arrived_reg;
                    if (arrived_reg)
                    begin
                        running_reg <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        if (stop_pend_reg)
                        begin
                            // stop follows the drive result, same angles
                            stop_pend_reg <= 1'b0;
                            lin_out_reg   <= '0;
                            ang_out_reg   <= '0;
                            status_reg    <= gtph_pkg::STAT_ARRIVED;
                            last_reg      <= 1'b1;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                dx_reg   <= DW'(goal_x_reg) - DW'(robot_x);
                dy_reg   <= DW'(goal_y_reg) - DW'(robot_y);
                head_reg <= robot_heading;
            end
            ST_MUL1:
            begin
                case (cnt_reg)
                    M1_DYY:  s_reg  <= prod_reg[SW-1:0];
                    M1_RR:   s_reg  <= s_reg + prod_reg[SW-1:0];
                    M1_END:
                    begin
                        r2_reg     <= prod_reg[31:0];
                        sq_v_reg   <= 64'(s_reg) << 14;
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        cx_reg     <= cx0;
                        cy_reg     <= cy0;
                        cz_reg     <= cz0;
                        nz_reg     <= (dx_reg != 0) || (dy_reg != 0);
                    end
                    default: s_reg <= s_reg;
                endcase
            end
            ST_ITER:
            begin
                sq_v_reg   <= sq_v_next;
                sq_res_reg <= sq_res_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (nz_reg && (32'(cnt_reg) < 32'(CORDIC_STEPS)))
                begin
                    cx_reg <= cx_next;
                    cy_reg <= cy_next;
                    cz_reg <= cz_next;
                end
            end
            ST_ANGLE:
            begin
                bear_reg    <= bear_c;
                err_reg     <= err_c;
                de_reg      <= 18'(err_c) - 18'(prev_reg);
                arrived_reg <= arrived_c;
            end
            ST_MUL2:
            begin
                case (cnt_reg)
                    M2_KP:
                    begin
                        mag_reg <= integ_reg[IW-1] ? $unsigned(-integ_reg)
                                                   : $unsigned(integ_reg);
                    end
                    M2_KD:   acc_reg   <= prod_reg[NW-1:0];
                    M2_KLO:  acc_reg   <= acc_reg + prod_reg[NW-1:0];
                    M2_KHI:  ilo_reg   <= prod_reg[47:0];
                    M2_SG:   iterm_reg <= iterm_c;
                    M2_END:  lin_reg   <= lin_c;
                    default: lin_reg   <= lin_reg;
                endcase
            end
            default:
            begin
                lin_reg <= lin_reg;
            end
        endcase
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign linear_vel     = lin_out_reg;
    assign angular_vel    = ang_out_reg;
    assign target_bearing = bear_out_reg;
    assign heading_error  = err_out_reg;
    assign status         = status_reg;
    assign last           = last_reg;

    // a request is only taken with no result pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !out_valid)
        else $error("request accepted while a result is pending");

    // the stop result carries no motion
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == gtph_pkg::STAT_ARRIVED) |->
        (linear_vel == 16'd0 && angular_vel == 21'sd0 && last))
        else $error("arrival stop result carries motion");

    // a canceled or arrived result leaves the block disarmed
    a_disarm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status != gtph_pkg::STAT_DRIVE) |=> !running_reg)
        else $error("block still armed after final result");

    // turn command stays inside the clamp
    a_turn_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == gtph_pkg::STAT_DRIVE) |->
        (angular_vel <= $signed({1'b0, mtr_reg}) &&
         angular_vel >= -$signed({1'b0, mtr_reg})))
        else $error("turn command outside clamp");

    // forward speed never exceeds the limit
    a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(linear_vel) <= 32'(MAX_FORWARD_SPEED)))
        else $error("forward speed above limit");

endmodule
